/* rtl/core/scalar_kalman_rate_fusion_macros.svh */
// Assertion macros for the yaw rate fusion block
`ifndef SCALAR_KALMAN_RATE_FUSION_MACROS_SVH
`define SCALAR_KALMAN_RATE_FUSION_MACROS_SVH
`ifndef SYNTHESIS
`define SKRF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SKRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SKRF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SKRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/skrf_pkg.sv */
// Shared types and constants for the yaw rate fusion block
package skrf_pkg;
    localparam int unsigned CMD_GYRO = 0;
    localparam int unsigned CMD_ODOM = 1;
    localparam int unsigned REG_INIT_VAR = 0;
    localparam int unsigned REG_MOTION_NOISE = 1;
    localparam int unsigned REG_MEAS_NOISE = 2;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned QUEUE_DEPTH = 2;
endpackage

/* rtl/core/scalar_kalman_rate_fusion.sv */
// Scalar Kalman filter fusing odometry and gyro yaw rates: top level
// Usage:
//   Input channel (i_valid/o_stall) carries i_cmd and i_rate_value.
//   Gyro items only latch the gyro rate; the first odometry item seeds the
//   estimate; later odometry items return one result on the output channel
//   (o_valid/i_stall): o_filtered_rate and o_error_variance, Q16.16.
//   Front end: a two-entry queue takes items while the back end works.
//   Back end: prediction, exact products, then (unless the innovation variance
//   is zero) two divisions of 2*VALUE_WIDTH+2 quotient bits each on one shared
//   bit-serial divider; gyro items are taken directly in the idle state.
//   Reset (synchronous, active low) clears the state and loads the
//   configuration defaults; the variance takes the default initial_variance
//   on the first cycle after reset. A stalled result holds and the back end
//   waits; the queue then fills and o_stall rises.
module scalar_kalman_rate_fusion #(
    parameter int unsigned FRAC_BITS   = 16,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_rate_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [VALUE_WIDTH-1:0] o_filtered_rate,
    output logic [VALUE_WIDTH-1:0] o_error_variance,
    input  logic                   i_cfg_we,
    input  logic [skrf_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [VALUE_WIDTH-1:0] i_cfg_data
);
    import skrf_pkg::*;
`include "scalar_kalman_rate_fusion_macros.svh"
    localparam int unsigned VW = VALUE_WIDTH;

    logic [VW-1:0] r_init_var, r_motion, r_meas;
    logic w_full, w_empty, w_pop, w_push;
    logic [VW:0] w_qdata;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_var <= VW'(1000) << FRAC_BITS;
            r_motion   <= VW'(4) << FRAC_BITS;
            r_meas     <= VW'(1) << (FRAC_BITS - 1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INDEX_WIDTH'(REG_INIT_VAR):     r_init_var <= i_cfg_data;
                CFG_INDEX_WIDTH'(REG_MOTION_NOISE): r_motion   <= i_cfg_data;
                CFG_INDEX_WIDTH'(REG_MEAS_NOISE):   r_meas     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = w_full;
    assign w_push  = i_valid && !w_full;

    skrf_queue #(.WIDTH(VW+1)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({i_cmd, i_rate_value}),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_data (w_qdata)
    );

    skrf_back #(.VW(VW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_item    (w_qdata),
        .o_pop     (w_pop),
        .i_init_var(r_init_var),
        .i_motion  (r_motion),
        .i_meas    (r_meas),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_rate    (o_filtered_rate),
        .o_var     (o_error_variance)
    );

    `SKRF_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_empty)
    `SKRF_ASSERT_IMPL(a_full_not_empty, i_clk, i_rst_n, w_full, !w_empty)
    `SKRF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
endmodule

/* rtl/core/skrf_queue.sv */
// Two-entry queue between the front and the back of the fusion block
module skrf_queue #(
    parameter int unsigned WIDTH = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    import skrf_pkg::*;
    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule

/* rtl/core/skrf_divider.sv */
// Iterative restoring divider, one quotient bit per cycle
module skrf_divider #(
    parameter int unsigned NUM_WIDTH = 128,
    parameter int unsigned DEN_WIDTH = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [DEN_WIDTH-1:0] i_den,
    output logic                 o_done,
    output logic [NUM_WIDTH-1:0] o_quot
);
    localparam int unsigned CW = $clog2(NUM_WIDTH + 1);
    logic [NUM_WIDTH-1:0] r_q;
    logic [DEN_WIDTH:0]   r_rem;
    logic [DEN_WIDTH-1:0] r_den;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic [DEN_WIDTH:0]   n_rem;
    logic                 n_ge;

    always_comb begin
        n_rem = {r_rem[DEN_WIDTH-1:0], r_q[NUM_WIDTH-1]};
        n_ge  = (n_rem >= {1'b0, r_den});
    end

    assign o_quot = r_q;

    // shift one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_rem - {1'b0, r_den}) : n_rem;
            r_q   <= {r_q[NUM_WIDTH-2:0], n_ge};
        end
    end
endmodule

/* rtl/core/skrf_back.sv */
// Back end: gyro latching, then prediction, update products and divisions for odometry items
module skrf_back #(
    parameter int unsigned VW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  logic [VW:0]   i_item,
    output logic          o_pop,
    input  logic [VW-1:0] i_init_var,
    input  logic [VW-1:0] i_motion,
    input  logic [VW-1:0] i_meas,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [VW-1:0] o_rate,
    output logic [VW-1:0] o_var
);
    import skrf_pkg::*;
    localparam int unsigned PW = 2 * VW + 2;
    localparam int unsigned NW = PW;

    typedef enum logic [3:0] {
        S_IDLE, S_PRED, S_MUL, S_SUM, S_WAIT1, S_WAIT2, S_OUT
    } t_state;

    t_state r_state;
    logic signed [VW-1:0] r_est, r_prev, r_gyro, r_z;
    logic [VW-1:0] r_var, r_v;
    logic [VW:0]   r_den;
    logic          r_first, r_init_pending;
    logic signed [PW-1:0] r_p1, r_p2;
    logic [2*VW-1:0] r_pvr;
    logic          r_neg;
    logic [NW-1:0] r_num;
    logic          r_dstart, w_ddone;
    logic [NW-1:0] w_quot;

    // predicted estimate and variance, product sum and clamped quotient
    logic signed [VW+1:0] w_sum;
    logic signed [VW-1:0] w_pred;
    logic [VW:0] w_vsum;
    logic [VW-1:0] w_vpred;
    logic signed [PW-1:0] w_tot;
    logic [NW-1:0] w_mag;
    logic [NW-1:0] w_qsat_pos, w_qsat_neg;
    logic [VW-1:0] w_qcl;

    always_comb begin
        w_sum = (VW+2)'(r_est) + (VW+2)'(r_z) - (VW+2)'(r_prev);
        if (w_sum > $signed({3'b000, {(VW-1){1'b1}}}))
            w_pred = {1'b0, {(VW-1){1'b1}}};
        else if (w_sum < $signed({3'b111, {(VW-1){1'b0}}}))
            w_pred = {1'b1, {(VW-1){1'b0}}};
        else
            w_pred = w_sum[VW-1:0];
        w_vsum  = {1'b0, r_var} + {1'b0, i_motion};
        w_vpred = w_vsum[VW] ? '1 : w_vsum[VW-1:0];
        w_tot   = r_p1 + r_p2;
        w_mag   = w_tot[PW-1] ? NW'(-w_tot) : NW'(w_tot);
        w_qsat_pos = NW'({1'b0, {(VW-1){1'b1}}});
        w_qsat_neg = NW'({1'b1, {(VW-1){1'b0}}});
        if (r_neg)
            w_qcl = (w_quot > w_qsat_neg) ? {1'b1, {(VW-1){1'b0}}} : VW'(-w_quot);
        else
            w_qcl = (w_quot > w_qsat_pos) ? {1'b0, {(VW-1){1'b1}}} : w_quot[VW-1:0];
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    skrf_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(VW+1)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_dstart),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_done (w_ddone),
        .o_quot (w_quot)
    );

    // sequence one item through prediction and update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_first <= 1'b1;
            r_init_pending <= 1'b1;
            r_est   <= '0;
            r_prev  <= '0;
            r_gyro  <= '0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (o_valid && !i_stall && r_state != S_OUT) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    // take the starting variance once, right after reset
                    if (r_init_pending) begin
                        r_var <= i_init_var;
                        r_init_pending <= 1'b0;
                    end
                    if (!i_empty) begin
                        if (i_item[VW] == 1'(CMD_GYRO)) begin
                            r_gyro <= i_item[VW-1:0];
                        end else if (r_first) begin
                            r_first <= 1'b0;
                            r_prev  <= i_item[VW-1:0];
                            r_est   <= i_item[VW-1:0];
                        end else begin
                            r_z     <= i_item[VW-1:0];
                            r_state <= S_PRED;
                        end
                    end
                end
                S_PRED: begin
                    r_est  <= w_pred;
                    r_v    <= w_vpred;
                    r_prev <= r_z;
                    r_den  <= {1'b0, w_vpred} + {1'b0, i_meas};
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p1  <= PW'(r_est) * $signed({1'b0, i_meas});
                    r_p2  <= PW'(r_gyro) * $signed({1'b0, r_v});
                    r_pvr <= r_v * i_meas;
                    if (r_den == '0) begin
                        r_var   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_neg    <= w_tot[PW-1];
                    r_num    <= w_mag;
                    r_dstart <= 1'b1;
                    r_state  <= S_WAIT1;
                end
                S_WAIT1: begin
                    if (w_ddone) begin
                        r_est    <= w_qcl;
                        r_num    <= NW'(r_pvr);
                        r_dstart <= 1'b1;
                        r_state  <= S_WAIT2;
                    end
                end
                S_WAIT2: begin
                    if (w_ddone) begin
                        r_var   <= w_quot[VW-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid <= 1'b1;
                        o_rate  <= r_est;
                        o_var   <= r_var;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
